[rtl/core/mrm_pkg.sv]
package mrm_pkg;

    // Operation codes carried in tuser
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_START = 2'd1,
        OP_MIX   = 2'd2,
        OP_QUERY = 2'd3
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [15:0] mem_address;
        logic [7:0]  sample_byte;
        logic [15:0] sound_length;
        logic [7:0]  sound_id;
        logic        exclusive;
        logic [6:0]  volume;
        logic [7:0]  separation;
        logic [7:0]  pitch;
        logic [31:0] game_tick;
        logic [15:0] query_handle;
    } t_item;

    typedef struct packed {
        logic signed [15:0] left_sample;
        logic signed [15:0] right_sample;
        logic [15:0]        voice_handle;
        logic               is_playing;
    } t_result;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXCL,
        ST_FREE,
        ST_SCAN,
        ST_PAN1,
        ST_PAN2,
        ST_MIX_RD,
        ST_MIX_MUL,
        ST_MIX_DIV,
        ST_MIX_ACC,
        ST_MIX_END,
        ST_DONE
    } t_eng_state;

    localparam int          STEP_W       = 18;
    localparam logic [15:0] HANDLE_FIRST = 16'd100;
    localparam logic [15:0] RECIP_127    = 16'd33027;
    localparam int          RECIP_SHIFT  = 22;
    localparam logic [8:0]  SILENCE      = 9'd128;

    typedef logic [STEP_W-1:0] t_step_rom [256];

    // Pitch step table: geometric steps up and down from unit rate
    function automatic t_step_rom build_step_rom();
        t_step_rom rom;
        logic [63:0] prod;
        rom[128] = STEP_W'(65536);
        for (int i = 1; i < 128; i++) begin
            prod = 64'(rom[127 + i]) * 64'd66250;
            rom[128 + i] = STEP_W'(prod >> 16);
        end
        for (int i = 1; i <= 128; i++) begin
            prod = 64'(rom[129 - i]) * 64'd64830;
            rom[128 - i] = STEP_W'(prod >> 16);
        end
        rom[192] = STEP_W'(131072);
        rom[64]  = STEP_W'(32768);
        return rom;
    endfunction

    localparam t_step_rom STEP_ROM = build_step_rom();

endpackage

[rtl/core/mrm_ram.sv]
module mrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/core/mrm_front.sv]
module mrm_front
    import mrm_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_item  i_item,
    output logic   o_item_valid,
    input  logic   i_item_pop,
    output t_item  o_item
);
    t_item      r_q [2];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       push, pop;

    assign o_ready      = (r_cnt != 2'd2);
    assign push         = i_valid && o_ready;
    assign o_item_valid = (r_cnt != 2'd0);
    assign pop          = i_item_pop && o_item_valid;
    assign o_item       = r_q[r_rp];

    // Advance queue pointers
    always_comb begin
        n_wp  = push ? ~r_wp : r_wp;
        n_rp  = pop ? ~r_rp : r_rp;
        n_cnt = r_cnt + 2'(push) - 2'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Hold accepted words
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_item;
        end
    end
endmodule

[rtl/core/mrm_engine.sv]
module mrm_engine
    import mrm_pkg::*;
#(
    parameter int VOICES = 8,
    parameter int AW     = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_item_valid,
    output logic          o_item_pop,
    input  t_item         i_item,
    output logic          o_ram_we,
    output logic [AW-1:0] o_ram_waddr,
    output logic [7:0]    o_ram_wdata,
    output logic [AW-1:0] o_ram_raddr,
    input  logic [7:0]    i_ram_rdata,
    output logic          o_valid,
    input  logic          i_ready,
    output t_result       o_result
);
    localparam int VW    = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int ACC_W = 18 + VW;

    t_eng_state r_state, n_state;
    t_item      r_item;
    t_result    r_res, r_odata;
    logic       r_ovalid;

    logic [VOICES-1:0] r_act;
    logic [16:0]       r_pos   [VOICES];
    logic [16:0]       r_end   [VOICES];
    logic [15:0]       r_frac  [VOICES];
    logic [STEP_W-1:0] r_step  [VOICES];
    logic [31:0]       r_tick  [VOICES];
    logic [15:0]       r_hnd   [VOICES];
    logic [7:0]        r_id    [VOICES];
    logic [6:0]        r_lv    [VOICES];
    logic [6:0]        r_rv    [VOICES];
    logic [15:0]       r_nh;

    logic [VW-1:0]       r_idx, r_slot;
    logic [31:0]         r_old;
    logic [16:0]         r_sql, r_sqr;
    logic signed [16:0]  r_pl, r_pr;
    logic [16:0]         r_ml, r_mr;
    logic                r_nl, r_nr;
    logic signed [ACC_W-1:0] r_accl, r_accr;

    logic          last_idx;
    logic          ex_found, free_found, hit;
    logic [VW-1:0] ex_slot, free_slot;
    logic [18:0]   adv_sum;
    logic [17:0]   adv_pos;
    logic [AW+16:0] pos_ext, wr_ext;
    logic [8:0]    s_val, t_mag;
    logic [23:0]   pan_l, pan_r;
    logic [15:0]   hnd_now;
    logic signed [8:0] b_ctr;
    logic [13:0]   abs_l, abs_r;
    logic [14:0]   y_l, y_r;
    logic [30:0]   qp_l, qp_r;
    logic signed [ACC_W-1:0] sum_l, sum_r;

    assign last_idx = (r_idx == VW'(VOICES - 1));

    // Find voices for exclusive stop, free slot and handle query
    always_comb begin
        ex_found   = 1'b0;
        ex_slot    = '0;
        free_found = 1'b0;
        free_slot  = '0;
        hit        = 1'b0;
        for (int i = 0; i < VOICES; i++) begin
            if (!ex_found && r_act[i] && r_id[i] == r_item.sound_id) begin
                ex_found = 1'b1;
                ex_slot  = VW'(i);
            end
            if (!free_found && !r_act[i]) begin
                free_found = 1'b1;
                free_slot  = VW'(i);
            end
            if (r_act[i] && r_hnd[i] == i_item.query_handle) begin
                hit = 1'b1;
            end
        end
    end

    // Voice advance and sample addressing
    always_comb begin
        adv_sum     = 19'(r_frac[r_idx]) + 19'(r_step[r_idx]);
        adv_pos     = 18'(r_pos[r_idx]) + 18'(adv_sum[18:16]);
        pos_ext     = (AW + 17)'(r_pos[r_idx]);
        wr_ext      = (AW + 17)'(i_item.mem_address);
        o_ram_raddr = pos_ext[AW-1:0];
        o_ram_waddr = wr_ext[AW-1:0];
        o_ram_wdata = i_item.sample_byte;
        o_ram_we    = (r_state == ST_IDLE) && i_item_valid && (i_item.op == OP_WRITE);
    end

    // Pan law and handle
    always_comb begin
        s_val   = 9'(r_item.separation) + 9'd1;
        t_mag   = 9'd256 - 9'(r_item.separation);
        pan_l   = 24'(r_item.volume) * 24'(r_sql);
        pan_r   = 24'(r_item.volume) * 24'(r_sqr);
        hnd_now = (r_nh == 16'd0) ? HANDLE_FIRST : r_nh;
    end

    // Volume scaling: 256*|p|/127 = 2|p| + 2|p|/127
    always_comb begin
        b_ctr = $signed({1'b0, i_ram_rdata}) - $signed(SILENCE);
        abs_l = r_pl[16] ? 14'(-r_pl) : 14'(r_pl);
        abs_r = r_pr[16] ? 14'(-r_pr) : 14'(r_pr);
        y_l   = {abs_l, 1'b0};
        y_r   = {abs_r, 1'b0};
        qp_l  = 31'(y_l) * 31'(RECIP_127);
        qp_r  = 31'(y_r) * 31'(RECIP_127);
        sum_l = r_accl + (r_nl ? -$signed(ACC_W'(r_ml)) : $signed(ACC_W'(r_ml)));
        sum_r = r_accr + (r_nr ? -$signed(ACC_W'(r_mr)) : $signed(ACC_W'(r_mr)));
    end

    // Next state
    always_comb begin
        n_state    = r_state;
        o_item_pop = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_item_pop = i_item_valid;
                if (i_item_valid) begin
                    case (i_item.op)
                        OP_START: n_state = ST_EXCL;
                        OP_MIX:   n_state = ST_MIX_RD;
                        default:  n_state = ST_DONE;
                    endcase
                end
            end
            ST_EXCL:    n_state = ST_FREE;
            ST_FREE:    n_state = free_found ? ST_PAN1 : ST_SCAN;
            ST_SCAN:    n_state = last_idx ? ST_PAN1 : ST_SCAN;
            ST_PAN1:    n_state = ST_PAN2;
            ST_PAN2:    n_state = ST_DONE;
            ST_MIX_RD: begin
                if (r_act[r_idx]) begin
                    n_state = ST_MIX_MUL;
                end else if (last_idx) begin
                    n_state = ST_MIX_END;
                end
            end
            ST_MIX_MUL: n_state = ST_MIX_DIV;
            ST_MIX_DIV: n_state = ST_MIX_ACC;
            ST_MIX_ACC: n_state = last_idx ? ST_MIX_END : ST_MIX_RD;
            ST_MIX_END: n_state = ST_DONE;
            ST_DONE:    n_state = (!r_ovalid || i_ready) ? ST_IDLE : ST_DONE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control state: voice activity, handle counter, output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act    <= '0;
            r_nh     <= 16'd0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == ST_DONE && (!r_ovalid || i_ready)) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_EXCL: begin
                    if (r_item.exclusive && ex_found) begin
                        r_act[ex_slot] <= 1'b0;
                    end
                end
                ST_PAN2: begin
                    r_act[r_slot] <= 1'b1;
                    r_nh          <= hnd_now + 16'd1;
                end
                ST_MIX_RD: begin
                    if (r_act[r_idx] && adv_pos >= {1'b0, r_end[r_idx]}) begin
                        r_act[r_idx] <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_item <= i_item;
                r_res.left_sample  <= '0;
                r_res.right_sample <= '0;
                r_res.voice_handle <= '0;
                r_res.is_playing   <= (i_item.op == OP_QUERY) && hit;
                r_idx  <= '0;
                r_accl <= '0;
                r_accr <= '0;
            end
            ST_FREE: begin
                r_old  <= r_item.game_tick;
                if (free_found) begin
                    r_slot <= free_slot;
                end else begin
                    r_slot <= '0;
                end
            end
            ST_SCAN: begin
                if (r_tick[r_idx] < r_old) begin
                    r_old  <= r_tick[r_idx];
                    r_slot <= r_idx;
                end
                r_idx <= r_idx + VW'(1);
            end
            ST_PAN1: begin
                r_sql <= 17'(s_val) * 17'(s_val);
                r_sqr <= 17'(t_mag) * 17'(t_mag);
            end
            ST_PAN2: begin
                r_pos[r_slot]  <= 17'(r_item.mem_address);
                r_end[r_slot]  <= 17'(r_item.mem_address) + 17'(r_item.sound_length);
                r_frac[r_slot] <= 16'd0;
                r_step[r_slot] <= STEP_ROM[r_item.pitch];
                r_tick[r_slot] <= r_item.game_tick;
                r_hnd[r_slot]  <= hnd_now;
                r_id[r_slot]   <= r_item.sound_id;
                r_lv[r_slot]   <= r_item.volume - pan_l[22:16];
                r_rv[r_slot]   <= r_item.volume - pan_r[22:16];
                r_res.voice_handle <= hnd_now;
            end
            ST_MIX_RD: begin
                if (r_act[r_idx]) begin
                    r_frac[r_idx] <= adv_sum[15:0];
                    r_pos[r_idx]  <= adv_pos[16:0];
                end else if (!last_idx) begin
                    r_idx <= r_idx + VW'(1);
                end
            end
            ST_MIX_MUL: begin
                r_pl <= $signed({1'b0, r_lv[r_idx]}) * b_ctr;
                r_pr <= $signed({1'b0, r_rv[r_idx]}) * b_ctr;
            end
            ST_MIX_DIV: begin
                r_ml <= 17'(y_l) + 17'(qp_l[30:RECIP_SHIFT]);
                r_mr <= 17'(y_r) + 17'(qp_r[30:RECIP_SHIFT]);
                r_nl <= r_pl[16];
                r_nr <= r_pr[16];
            end
            ST_MIX_ACC: begin
                r_accl <= sum_l;
                r_accr <= sum_r;
                if (!last_idx) begin
                    r_idx <= r_idx + VW'(1);
                end
            end
            ST_MIX_END: begin
                if (r_accl > ACC_W'(32767)) begin
                    r_res.left_sample <= 16'sh7fff;
                end else if (r_accl < -$signed(ACC_W'(32768))) begin
                    r_res.left_sample <= -16'sh8000;
                end else begin
                    r_res.left_sample <= 16'(r_accl);
                end
                if (r_accr > ACC_W'(32767)) begin
                    r_res.right_sample <= 16'sh7fff;
                end else if (r_accr < -$signed(ACC_W'(32768))) begin
                    r_res.right_sample <= -16'sh8000;
                end else begin
                    r_res.right_sample <= 16'(r_accr);
                end
            end
            ST_DONE: begin
                if (!r_ovalid || i_ready) begin
                    r_odata <= r_res;
                end
            end
            default: ;
        endcase
    end

    assign o_valid  = r_ovalid;
    assign o_result = r_odata;

    // The replacement scan runs only when every voice is busy
    a_scan_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SCAN |-> &r_act)
        else $error("replacement scan with a free voice");

    // A start always hands out a nonzero handle
    a_handle_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_PAN2 |=> r_res.voice_handle != 16'd0)
        else $error("start produced handle zero");

    // The started voice is active right after it is placed
    a_start_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_PAN2 |=> r_act[$past(r_slot)])
        else $error("started voice not active");
endmodule

[rtl/core/multichannel_resampling_mixer.sv]
// Eight-voice 8-bit sample mixer. Each input word carries an operation in
// tuser: write a sample byte, start a voice, mix one stereo sample, or query
// a handle; each word produces exactly one result word. Words are queued two
// deep and then executed one at a time by a sequencer that walks the voices
// through the single read port of the sample memory. The memory depth must
// be a power of two; unwritten bytes read undefined.
module multichannel_resampling_mixer
    import mrm_pkg::*;
#(
    parameter int VOICES           = 8,
    parameter int SAMPLE_MEM_DEPTH = 65536
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // mem_address, sample_byte, sound_length, sound_id, exclusive, volume,
    // separation, pitch, game_tick, query_handle
    input  logic [119:0] s_axis_tdata,
    // operation
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // left_sample, right_sample, voice_handle, is_playing, zero fill
    output logic [55:0]  m_axis_tdata
);
    localparam int AW = $clog2(SAMPLE_MEM_DEPTH);

    t_item   in_item, q_item;
    t_result res;
    logic    q_valid, q_pop;
    logic    ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_wdata, ram_rdata;

    // Unpack the incoming word
    always_comb begin
        in_item.op           = t_op'(s_axis_tuser);
        in_item.mem_address  = s_axis_tdata[15:0];
        in_item.sample_byte  = s_axis_tdata[23:16];
        in_item.sound_length = s_axis_tdata[39:24];
        in_item.sound_id     = s_axis_tdata[47:40];
        in_item.exclusive    = s_axis_tdata[48];
        in_item.volume       = s_axis_tdata[55:49];
        in_item.separation   = s_axis_tdata[63:56];
        in_item.pitch        = s_axis_tdata[71:64];
        in_item.game_tick    = s_axis_tdata[103:72];
        in_item.query_handle = s_axis_tdata[119:104];
    end

    mrm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_item       (in_item),
        .o_item_valid (q_valid),
        .i_item_pop   (q_pop),
        .o_item       (q_item)
    );

    mrm_ram #(
        .WIDTH (8),
        .DEPTH (SAMPLE_MEM_DEPTH)
    ) u_samples (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    mrm_engine #(
        .VOICES (VOICES),
        .AW     (AW)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (q_valid),
        .o_item_pop   (q_pop),
        .i_item       (q_item),
        .o_ram_we     (ram_we),
        .o_ram_waddr  (ram_waddr),
        .o_ram_wdata  (ram_wdata),
        .o_ram_raddr  (ram_raddr),
        .i_ram_rdata  (ram_rdata),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_result     (res)
    );

    // Pack the result word
    assign m_axis_tdata = {7'd0, res.is_playing, res.voice_handle,
                           res.right_sample, res.left_sample};
endmodule
